>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the receive FIFO.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high
`define URXF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset
`define URXF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/urxf_pkg.sv
// ----------------------------------------------------------------------------
// urxf_pkg
// Types and constants shared by the receive FIFO modules.
// ----------------------------------------------------------------------------
package urxf_pkg;

  // Default ring size (holds one byte less than this)
  localparam int SLOTS_DEF = 64;

  localparam int BYTE_W    = 8;
  localparam int FILL_W    = 6;
  localparam int WM_W      = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [WM_W-1:0] HIGH_WM_RESET = 6'd48;
  localparam logic [WM_W-1:0] LOW_WM_RESET  = 6'd5;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_WM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WM  = 2'd1;

  // Item kinds
  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [WM_W-1:0] high;
    logic [WM_W-1:0] low;
  } watermarks_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_t;

endpackage

>>> hdl/urxf_ram.sv
// ----------------------------------------------------------------------------
// urxf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module urxf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/urxf_ctrl.sv
// ----------------------------------------------------------------------------
// urxf_ctrl
// Pointer, fill count and hold-off control with the result register.
// ----------------------------------------------------------------------------
module urxf_ctrl #(
  parameter int SLOTS = urxf_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  urxf_pkg::watermarks_t       wm,
  // item in
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [urxf_pkg::BYTE_W-1:0] rx_byte,
  // result out
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [urxf_pkg::BYTE_W-1:0] read_byte,
  output logic                        read_ok,
  output logic                        dropped,
  output logic [urxf_pkg::FILL_W-1:0] fill_level,
  output logic                        hold_off,
  // slot memory
  output logic                        mem_we,
  output logic [$clog2(SLOTS)-1:0]    mem_waddr,
  output logic [urxf_pkg::BYTE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(SLOTS)-1:0]    mem_raddr,
  input  logic [urxf_pkg::BYTE_W-1:0] mem_rdata
);
  import urxf_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CMP_W = IDX_W + WM_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  ctrl_state_t      st, st_next;
  logic [IDX_W-1:0] wr_idx, rd_idx, count;
  logic             stop;

  logic             accept, is_store, is_drop, is_read;
  logic [IDX_W-1:0] count_next;
  logic             stop_next;
  logic [CMP_W-1:0] count_ext, high_ext, low_ext;

  // Handshake: one item in flight, never overwrite a stalled result
  assign in_stall = (st == ST_READ) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign is_store = accept && (kind == KIND_RX) && (count != LAST);
  assign is_drop  = accept && (kind == KIND_RX) && (count == LAST);
  assign is_read  = accept && (kind == KIND_READ) && (count != '0);

  // New count and hold-off level
  always_comb begin
    count_next = count;
    if (is_store) begin
      count_next = count + 1'b1;
    end else if (is_read) begin
      count_next = count - 1'b1;
    end
  end

  assign count_ext = CMP_W'(count_next);
  assign high_ext  = CMP_W'(wm.high);
  assign low_ext   = CMP_W'(wm.low);

  always_comb begin
    stop_next = stop;
    if (is_store && (count_ext >= high_ext)) begin
      stop_next = 1'b1;
    end else if (is_read && (count_ext < low_ext)) begin
      stop_next = 1'b0;
    end
  end

  // Slot memory access
  assign mem_we    = is_store;
  assign mem_waddr = wr_idx;
  assign mem_wdata = rx_byte;
  assign mem_re    = is_read;
  assign mem_raddr = rd_idx;

  // Sequencer: a hit read waits in ST_READ for the registered memory read
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (is_read) begin
          st_next = ST_READ;
        end
      end
      ST_READ: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Ring pointers, count and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
      stop   <= 1'b0;
    end else begin
      if (is_store) begin
        wr_idx <= (wr_idx == LAST) ? '0 : wr_idx + 1'b1;
      end
      if (is_read) begin
        rd_idx <= (rd_idx == LAST) ? '0 : rd_idx + 1'b1;
      end
      count <= count_next;
      stop  <= stop_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= !is_read;
    end else if (st == ST_READ) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_byte  <= '0;
      read_ok    <= is_read;
      dropped    <= is_drop;
      fill_level <= count_ext[FILL_W-1:0];
      hold_off   <= stop_next;
    end else if (st == ST_READ) begin
      read_byte <= mem_rdata;
    end
  end

endmodule

>>> hdl/uart_rx_fifo_rts_watermark.sv
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_watermark
// UART receive ring buffer with RTS hold-off watermarks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): kind 0 stores rx_byte, kind 1 reads the
//   oldest byte. Each item gives exactly one result on the output channel
//   (out_valid/out_stall): read_byte/read_ok, dropped, fill_level, hold_off.
//   The ring holds SLOTS-1 bytes; an arrival when full is dropped.
//   Arrivals, drops and reads of an empty buffer give their result in the
//   cycle after acceptance; a read that returns a byte first passes the
//   ST_READ state, which waits for the registered read of the slot RAM.
//   Throughput: one item per cycle while no result is stalled, except
//   that the input stalls in ST_READ after a read that returns a byte.
//   A stalled result is held in the output register; the input then stalls
//   until that result is taken.
//   Configuration port (cfg_valid/cfg_ready, always ready): index 0 sets the
//   high watermark, index 1 the low watermark; other indexes are ignored.
//   Reset empties the buffer, clears hold-off and restores watermarks 48 / 5.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_rx_fifo_rts_watermark #(
  parameter int SLOTS = urxf_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [urxf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urxf_pkg::WM_W-1:0]      cfg_data,
  // items in
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [urxf_pkg::BYTE_W-1:0]    rx_byte,
  // results out
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [urxf_pkg::BYTE_W-1:0]    read_byte,
  output logic                           read_ok,
  output logic                           dropped,
  output logic [urxf_pkg::FILL_W-1:0]    fill_level,
  output logic                           hold_off
);
  import urxf_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  watermarks_t      wm;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  // Watermark registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wm.high <= HIGH_WM_RESET;
      wm.low  <= LOW_WM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIGH_WM: wm.high <= cfg_data;
        REG_LOW_WM:  wm.low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control
  urxf_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .wm        (wm),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_byte (read_byte),
    .read_ok   (read_ok),
    .dropped   (dropped),
    .fill_level(fill_level),
    .hold_off  (hold_off),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Slot store
  urxf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Checks
  `URXF_ASSERT(a_no_overwrite, clk, rst, out_valid && out_stall |-> in_stall, "stalled result not protected")
  `URXF_ASSERT(a_item_progress, clk, rst, in_valid && !in_stall |=> out_valid || in_stall, "accepted item lost")
  `URXF_ASSERT(a_miss_zero, clk, rst, out_valid && !read_ok |-> read_byte == '0, "read_byte set without read_ok")

endmodule

>>> sim/urxf_result_check.sv
// ----------------------------------------------------------------------------
// urxf_result_check
// Watches the configuration, item and result channels of the receive FIFO.
// Keeps its own copy of the ring, fill level, hold-off flag and watermarks,
// works out the result of every accepted item and compares it, field by
// field, with what the block returns.
// ----------------------------------------------------------------------------
module urxf_result_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [urxf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urxf_pkg::WM_W-1:0]      cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           kind,
  input  logic [urxf_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [urxf_pkg::BYTE_W-1:0]    read_byte,
  input  logic                           read_ok,
  input  logic                           dropped,
  input  logic [urxf_pkg::FILL_W-1:0]    fill_level,
  input  logic                           hold_off,
  input  logic                           end_check,
  output int                             fail_count,
  output int                             outstanding
);
  import urxf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_ok;
    logic              drop;
    logic [FILL_W-1:0] level;
    logic              stop;
  } rx_result_t;

  // Own copy of the ring and its bookkeeping
  logic [BYTE_W-1:0] ring [SLOTS_DEF];
  int                wr_ptr;
  int                rd_ptr;
  int                held;
  logic              stop_req;
  logic [WM_W-1:0]   high_wm;
  logic [WM_W-1:0]   low_wm;

  rx_result_t pending_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic note_mismatch(input string msg);
    $display("[%0t] urxf mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Applies one item to the copy of the ring and returns what the block
  // should report for it
  function automatic rx_result_t next_fifo_result(input logic k, input logic [BYTE_W-1:0] b);
    rx_result_t r;
    r = '0;
    if (k == KIND_RX) begin
      if (held < SLOTS_DEF - 1) begin
        ring[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % SLOTS_DEF;
        held++;
        if (held >= high_wm) stop_req = 1'b1;
      end else begin
        // full: byte is lost, nothing else moves
        r.drop = 1'b1;
      end
    end else if (held != 0) begin
      r.rd_byte = ring[rd_ptr];
      r.rd_ok   = 1'b1;
      rd_ptr = (rd_ptr + 1) % SLOTS_DEF;
      held--;
      if (held < low_wm) stop_req = 1'b0;
    end
    r.level = held[FILL_W-1:0];
    r.stop  = stop_req;
    return r;
  endfunction

  // All channels are sampled on the rising edge
  always @(posedge clk) begin
    rx_result_t want;
    if (rst) begin
      wr_ptr   = 0;
      rd_ptr   = 0;
      held     = 0;
      stop_req = 1'b0;
      high_wm  = HIGH_WM_RESET;
      low_wm   = LOW_WM_RESET;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HIGH_WM) high_wm = cfg_data;
        else if (cfg_index == REG_LOW_WM) low_wm = cfg_data;
      end

      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with no item waiting");
        end else begin
          want = pending_results.pop_front();
          if (read_byte !== want.rd_byte)
            note_mismatch($sformatf("read_byte %0h, want %0h", read_byte, want.rd_byte));
          if (read_ok !== want.rd_ok)
            note_mismatch($sformatf("read_ok %0b, want %0b", read_ok, want.rd_ok));
          if (dropped !== want.drop)
            note_mismatch($sformatf("dropped %0b, want %0b", dropped, want.drop));
          if (fill_level !== want.level)
            note_mismatch($sformatf("fill_level %0d, want %0d", fill_level, want.level));
          if (hold_off !== want.stop)
            note_mismatch($sformatf("hold_off %0b, want %0b", hold_off, want.stop));
        end
      end

      if (in_valid && !in_stall)
        pending_results.push_back(next_fifo_result(kind, rx_byte));

      if (end_check && pending_results.size() != 0) begin
        note_mismatch($sformatf("%0d results never came", pending_results.size()));
        pending_results.delete();
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> sim/uart_rx_fifo_rts_watermark_test.sv
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_watermark_test
// Drives the receive FIFO with a short directed sequence and then phases of
// random arrivals and reads that fill, overflow and empty the ring under
// several watermark settings, with random gaps and output stalls.
// Checking is done by urxf_result_check.
// ----------------------------------------------------------------------------
module uart_rx_fifo_rts_watermark_test;
  import urxf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int                   PHASES     = 8;
  localparam int                   PHASE_LEN  = 70;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WM_W-1:0]      cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 kind;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    read_byte;
  logic                 read_ok;
  logic                 dropped;
  logic [FILL_W-1:0]    fill_level;
  logic                 hold_off;
  logic                 end_check;
  logic                 no_gaps;
  int                   fail_count;
  int                   outstanding;

  // Per-phase watermarks (extremes first) and share of arrivals in percent
  int phase_high [PHASES] = '{63, 0, 48, 1, 32, 0, 0, 0};
  int phase_low  [PHASES] = '{0, 63, 5, 62, 32, 0, 0, 0};
  int phase_rx   [PHASES] = '{95, 10, 90, 30, 60, 95, 5, 50};

  uart_rx_fifo_rts_watermark dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_byte  (read_byte),
    .read_ok    (read_ok),
    .dropped    (dropped),
    .fill_level (fill_level),
    .hold_off   (hold_off)
  );

  urxf_result_check check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_byte   (read_byte),
    .read_ok     (read_ok),
    .dropped     (dropped),
    .fill_level  (fill_level),
    .hold_off    (hold_off),
    .end_check   (end_check),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 20 unit clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 36);
  endfunction

  // Receiver side back-pressure
  always @(negedge clk) begin
    out_stall <= take_gap();
  end

  // Presents one item; returns at the falling edge after it was accepted,
  // with in_valid still high
  task automatic send_item(input logic k, input logic [BYTE_W-1:0] b);
    while (take_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind     = k;
    rx_byte  = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stops sending and waits for every outstanding result
  task automatic drain_results();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Writes both watermarks back to back, optionally followed by a write to
  // an unused index that must be ignored
  task automatic program_watermarks(input logic [WM_W-1:0] hi, input logic [WM_W-1:0] lo,
                                    input bit with_unused);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = REG_HIGH_WM;
    cfg_data  = hi;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index = REG_LOW_WM;
    cfg_data  = lo;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (with_unused) begin
      cfg_index = REG_UNUSED;
      cfg_data  = WM_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_HIGH_WM;
    cfg_data  = '0;
    in_valid  = 1'b0;
    kind      = KIND_RX;
    rx_byte   = '0;
    out_stall = 1'b0;
    end_check = 1'b0;
    no_gaps   = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: read of an empty ring, byte extremes, reads back in order
    send_item(KIND_READ, 8'hFF);
    send_item(KIND_RX, 8'h00);
    send_item(KIND_RX, 8'hFF);
    send_item(KIND_RX, 8'hA5);
    send_item(KIND_RX, 8'h5A);
    repeat (4) send_item(KIND_READ, 8'h00);
    send_item(KIND_READ, 8'h00);

    // Zero watermarks: every store raises hold-off, no read lowers it
    program_watermarks(6'd0, 6'd0, 1'b0);
    send_item(KIND_RX, 8'h3C);
    send_item(KIND_READ, 8'hC3);
    send_item(KIND_READ, 8'h00);

    // Top watermarks: hold-off left high from before, a read drops it
    program_watermarks(6'd63, 6'd63, 1'b0);
    send_item(KIND_RX, 8'h81);
    send_item(KIND_RX, 8'h7E);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_READ, 8'hFF);

    // Random phases: alternate filling past capacity and emptying the ring
    for (int p = 0; p < PHASES; p++) begin
      if (p >= 5) begin
        phase_high[p] = $urandom_range(63);
        phase_low[p]  = $urandom_range(63);
      end
      program_watermarks(WM_W'(phase_high[p]), WM_W'(phase_low[p]), p == 2);
      no_gaps = (p == 4);
      for (int i = 0; i < PHASE_LEN; i++) begin
        // the sender holds off once mid-phase until all results are in
        if (p == 3 && i == PHASE_LEN / 2) drain_results();
        if ($urandom_range(99) < phase_rx[p])
          send_item(KIND_RX, pick_byte());
        else
          send_item(KIND_READ, pick_byte());
      end
      no_gaps = 1'b0;
    end

    // Wind down and give the verdict
    drain_results();
    repeat (10) @(negedge clk);
    end_check = 1'b1;
    @(negedge clk);
    end_check = 1'b0;
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
